### hdl/bitmap_set_clear_find_first_defines.svh
// Assertion helpers for the bit map block.
// Both forms sample on i_clk and are off while i_rst_n is low.
`ifndef BITMAP_SET_CLEAR_FIND_FIRST_DEFINES_SVH
`define BITMAP_SET_CLEAR_FIND_FIRST_DEFINES_SVH

// same-cycle implication
`define BSCFF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSCFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bscff_pkg.sv
package bscff_pkg;

    localparam int MAP_BYTES_DEF = 32;
    // an 8-bit offset reaches 32 bytes at most
    localparam int MAX_MAP_BYTES = 32;
    localparam int SPAN_LIMIT    = 256;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] bit_offset;
        logic [8:0] span;
    } t_item;

    typedef struct packed {
        logic       found;
        logic [7:0] position;
    } t_res;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SET,
        OP_SEARCH,
        OP_MISS
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] offset;
        logic [8:0] end_bit;   // first bit past the searched range
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    function automatic logic [7:0] place_mask(input logic [2:0] p, input logic msb_first);
        if (msb_first) begin
            return 8'h80 >> p;
        end
        return 8'h01 << p;
    endfunction

endpackage

### hdl/bitmap_set_clear_find_first.sv
// Bit map with set, clear and find-first-set.
// Item channel (i_item_valid / o_item_ready / i_item): one command per beat.
//   Clear and set change one bit and give no result; search gives one result
//   beat on the result channel (o_res_valid / i_res_ready / o_res).
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): msb_first bit,
//   always ready; write it only while the block is idle.
// Commands enter a two-deep queue, so the item channel keeps taking beats
//   while the scan unit works or a result waits.
// Timing: set and clear execute one cycle after acceptance and sustain one
//   per cycle. A search spends one dispatch cycle, then one cycle per map
//   byte scanned (1 to 32), ending at the first hit or at the range end; the
//   result register is loaded at that edge. A search starting past the map
//   end costs one cycle. The single-byte read port of the map sets this rate.
// Receiver stall: the result register holds; the scan unit waits with its
//   finished result, the queue fills, then o_item_ready drops.
// Reset: map cleared in the same cycle (flip-flops), msb_first = 0, queue
//   and result register empty.
module bitmap_set_clear_find_first #(
    parameter int MAP_BYTES = bscff_pkg::MAP_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  bscff_pkg::t_item i_item,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output bscff_pkg::t_res  o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data
);
    import bscff_pkg::*;

    logic r_msb_first;
    logic push;
    t_op  push_op;
    logic full;
    logic head_valid;
    t_op  head;
    logic pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_first <= 1'b0;
        end else if (i_cfg_valid) begin
            r_msb_first <= i_cfg_data;
        end
    end

    bscff_front #(
        .MAP_BYTES(MAP_BYTES)
    ) u_front (
        .i_item_valid(i_item_valid),
        .o_item_ready(o_item_ready),
        .i_item      (i_item),
        .i_full      (full),
        .o_push      (push),
        .o_op        (push_op)
    );

    bscff_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_op   (push_op),
        .o_full      (full),
        .o_head_valid(head_valid),
        .o_head      (head),
        .i_pop       (pop)
    );

    bscff_back #(
        .MAP_BYTES(MAP_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_msb_first (r_msb_first),
        .i_head_valid(head_valid),
        .i_head      (head),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule

### hdl/bscff_front.sv
module bscff_front #(
    parameter int MAP_BYTES = bscff_pkg::MAP_BYTES_DEF
) (
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  bscff_pkg::t_item i_item,
    input  logic             i_full,
    output logic             o_push,
    output bscff_pkg::t_op   o_op
);
    import bscff_pkg::*;

    localparam int USED_BYTES = (MAP_BYTES < MAX_MAP_BYTES) ? MAP_BYTES : MAX_MAP_BYTES;
    localparam int USED_BITS  = USED_BYTES * 8;

    logic       in_map;
    logic [8:0] offset_x;
    logic [8:0] span_c;
    logic [8:0] room;
    logic [8:0] limit;
    logic       keep;

    assign offset_x = {1'b0, i_item.bit_offset};
    assign in_map   = offset_x < 9'(USED_BITS);
    assign span_c   = (i_item.span > 9'(SPAN_LIMIT)) ? 9'(SPAN_LIMIT) : i_item.span;
    assign room     = 9'(USED_BITS) - offset_x;
    assign limit    = (span_c > room) ? room : span_c;

    always_comb begin
        keep          = 1'b0;
        o_op.kind     = OP_MISS;
        o_op.offset   = i_item.bit_offset;
        o_op.end_bit  = offset_x + limit;
        case (i_item.cmd)
            CMD_CLEAR: begin
                keep      = in_map;
                o_op.kind = OP_CLEAR;
            end
            CMD_SET: begin
                keep      = in_map;
                o_op.kind = OP_SET;
            end
            CMD_SEARCH: begin
                keep      = 1'b1;
                o_op.kind = in_map ? OP_SEARCH : OP_MISS;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // dropped commands are still taken off the channel
    assign o_item_ready = !i_full;
    assign o_push       = i_item_valid && !i_full && keep;

endmodule

### hdl/bscff_fifo.sv
module bscff_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bscff_pkg::t_op i_push_op,
    output logic           o_full,
    output logic           o_head_valid,
    output bscff_pkg::t_op o_head,
    input  logic           i_pop
);
    import bscff_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count,  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full       = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

### hdl/bscff_back.sv
module bscff_back #(
    parameter int MAP_BYTES = bscff_pkg::MAP_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_msb_first,
    input  logic            i_head_valid,
    input  bscff_pkg::t_op  i_head,
    output logic            o_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output bscff_pkg::t_res o_res
);
    import bscff_pkg::*;

    localparam int USED_BYTES = (MAP_BYTES < MAX_MAP_BYTES) ? MAP_BYTES : MAX_MAP_BYTES;
    localparam int BYTE_W     = (USED_BYTES > 1) ? $clog2(USED_BYTES) : 1;

    logic [7:0]        r_map [USED_BYTES];
    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_ptr, n_ptr;
    logic [8:0]        r_start, n_start;
    logic [8:0]        r_end, n_end;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    logic [BYTE_W-1:0] head_ptr;
    logic [BYTE_W-1:0] rd_addr;
    logic [7:0]        rd_byte;
    logic [7:0]        head_mask;
    logic              map_we;
    logic [7:0]        map_wdata;
    logic [8:0]        byte_base;
    logic [7:0]        hit_vec;
    logic              hit;
    logic [2:0]        hit_place;
    logic              last;
    logic [8:0]        hit_bit;
    logic              out_free;

    assign head_ptr  = i_head.offset[3 +: BYTE_W];
    assign rd_addr   = (r_state == ST_IDLE) ? head_ptr : r_ptr;
    assign rd_byte   = r_map[rd_addr];
    assign head_mask = place_mask(i_head.offset[2:0], i_msb_first);
    assign byte_base = 9'({r_ptr, 3'b000});
    assign last      = (byte_base + 9'd8) >= r_end;
    assign out_free  = !r_out_valid || i_res_ready;

    // per-place match inside the current byte, limited to [start, end)
    always_comb begin
        logic [8:0] b;
        for (int p = 0; p < 8; p++) begin
            b          = byte_base + 9'(p);
            hit_vec[p] = (b >= r_start) && (b < r_end) &&
                         ((rd_byte & place_mask(3'(p), i_msb_first)) != 8'h00);
        end
    end

    always_comb begin
        hit_place = 3'd0;
        for (int p = 7; p >= 0; p--) begin
            if (hit_vec[p]) begin
                hit_place = 3'(p);
            end
        end
    end

    assign hit     = hit_vec != 8'h00;
    assign hit_bit = byte_base + {6'd0, hit_place};

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_start     = r_start;
        n_end       = r_end;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        map_we      = 1'b0;
        map_wdata   = rd_byte;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    case (i_head.kind)
                        OP_SET: begin
                            map_we    = 1'b1;
                            map_wdata = rd_byte | head_mask;
                            o_pop     = 1'b1;
                        end
                        OP_CLEAR: begin
                            map_we    = 1'b1;
                            map_wdata = rd_byte & ~head_mask;
                            o_pop     = 1'b1;
                        end
                        OP_SEARCH: begin
                            n_ptr   = head_ptr;
                            n_start = {1'b0, i_head.offset};
                            n_end   = i_head.end_bit;
                            o_pop   = 1'b1;
                            n_state = ST_SCAN;
                        end
                        OP_MISS: begin
                            if (out_free) begin
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                o_pop       = 1'b1;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit || last) begin
                    if (out_free) begin
                        n_out_valid    = 1'b1;
                        n_out.found    = hit;
                        n_out.position = hit ? 8'(hit_bit - r_start) : 8'd0;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    n_ptr = r_ptr + BYTE_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < USED_BYTES; i++) begin
                r_map[i] <= 8'h00;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (map_we) begin
                r_map[rd_addr] <= map_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_start <= n_start;
        r_end   <= n_end;
        r_out   <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### hdl/bscff_checker.sv
`include "bitmap_set_clear_find_first_defines.svh"

module bscff_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_res_valid,
    input logic             i_res_ready,
    input bscff_pkg::t_res  o_res
);

    `BSCFF_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready, o_res_valid, "result beat dropped")
    `BSCFF_ASSERT_NEXT(a_res_stable, o_res_valid && !i_res_ready, $stable(o_res), "result changed")
    `BSCFF_ASSERT_NOW(a_miss_zero, o_res_valid && !o_res.found, o_res.position == 8'd0, "miss pos")
    `BSCFF_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !o_res_valid, "result after reset")

endmodule

bind bitmap_set_clear_find_first bscff_checker u_bscff_checker (.*);
